[hdl/ple_pkg.sv]
// ple_pkg: shared types and constants for the positional list engine
// command and status codes, stream field layout, sequencer states, memory request struct
// no dependencies
`timescale 1ns / 1ps

package ple_pkg;

   // field widths
   localparam int CMD_W    = 3;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // memory address width covers the largest supported depth
   localparam int MEM_AW = 6;

   // stream payload layout
   localparam int REQ_CMD_LSB  = 0;
   localparam int REQ_VAL_LSB  = REQ_CMD_LSB + CMD_W;
   localparam int REQ_POS_LSB  = REQ_VAL_LSB + VAL_W;
   localparam int REQ_BITS     = REQ_POS_LSB + POS_W;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_STAT_LSB = 0;
   localparam int RSP_CNT_LSB  = RSP_STAT_LSB + STATUS_W;
   localparam int RSP_VAL_LSB  = RSP_CNT_LSB + COUNT_W;
   localparam int RSP_BITS     = RSP_VAL_LSB + VAL_W;
   localparam int RSP_TDATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE,
      S_RESP,
      S_DUMP_RD,
      S_DUMP_WAIT
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
   } mem_req_type;

endpackage

[hdl/positional_list_engine.sv]
// positional_list_engine: bounded ordered list of signed 32-bit entries
// sequencer, decode and result register; entries live in ple_store
// depends on ple_pkg and ple_store
`timescale 1ns / 1ps

//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata: command, value, position
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: status, entry_count, read_value;
//          |     |                       | rsp_tlast: last result of the command
//
// steps: insert or delete reads each of the m moved entries and writes it one slot over, then
//   stores the new value or updates the count and loads the result (errors load it directly);
//   worst case m = DEPTH - 1; a dump reads each entry from memory, then loads it as a result
// reset: synchronous, empties the list; memory contents are never cleared
// stalls: a new command is taken while the last result still waits in the
//   output register; the sequencer only waits when it must load a new result

module positional_list_engine #(
   parameter int DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command[2:0], value[34:3], position[40:35], zero fill to 48 bits
   input  logic [ple_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], entry_count[7:2], read_value[39:8]
   output logic [ple_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import ple_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = ((CW > POS_W) ? CW : POS_W) + 1;

   // request fields
   logic [CMD_W-1:0] req_cmd;
   logic [VAL_W-1:0] req_value;
   logic [POS_W-1:0] req_pos;

   assign req_cmd   = req_tdata[REQ_CMD_LSB +: CMD_W];
   assign req_value = req_tdata[REQ_VAL_LSB +: VAL_W];
   assign req_pos   = req_tdata[REQ_POS_LSB +: POS_W];

   // control state
   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        left_ff, left_in;      // entries still to read
   logic [AW-1:0]        ptr_ff, ptr_in;        // next read address
   logic                 pend_ff, pend_in;      // read data waiting to be written
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   logic [AW-1:0]        idx_ff, idx_in;        // slot of the new entry
   logic                 ins_ff, ins_in;
   logic [VAL_W-1:0]     val_ff, val_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   mem_req_type          mem_req;
   logic [VAL_W-1:0]     rd_data;

   logic                 req_fire;
   logic                 out_free;

   // decode results
   state_type            dec_state;
   logic [STATUS_W-1:0]  dec_status;
   logic                 dec_ins;
   logic [KW-1:0]        dec_idx;
   logic [CW-1:0]        dec_left;
   logic [AW-1:0]        dec_ptr;

   logic [KW-1:0]        occ_x;
   logic [KW-1:0]        pos_x;
   logic                 full;
   logic                 empty;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign occ_x = KW'(cnt_ff);
   assign pos_x = KW'(req_pos);
   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);

   ple_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data)
   );

   // command decode: range and room checks, shift extent
   always_comb begin
      dec_state  = S_RESP;
      dec_status = STAT_OK;
      dec_ins    = 1'b0;
      dec_idx    = '0;
      unique case (req_cmd)
         CMD_INS_FRONT: begin
            if (full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_state = S_MOVE;
               dec_ins   = 1'b1;
            end
         end
         CMD_INS_BACK: begin
            if (full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_state = S_MOVE;
               dec_ins   = 1'b1;
               dec_idx   = occ_x;
            end
         end
         CMD_INS_POS: begin
            if (pos_x == '0 || pos_x > occ_x + KW'(1)) begin
               dec_status = STAT_BADPOS;
            end else if (full) begin
               dec_status = STAT_FULL;
            end else begin
               dec_state = S_MOVE;
               dec_ins   = 1'b1;
               dec_idx   = pos_x - KW'(1);
            end
         end
         CMD_DEL_FRONT: begin
            if (empty) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_state = S_MOVE;
            end
         end
         CMD_DEL_BACK: begin
            if (empty) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_state = S_MOVE;
               dec_idx   = occ_x - KW'(1);
            end
         end
         CMD_DEL_POS: begin
            if (pos_x == '0 || pos_x > occ_x) begin
               dec_status = STAT_BADPOS;
            end else begin
               dec_state = S_MOVE;
               dec_idx   = pos_x - KW'(1);
            end
         end
         CMD_DUMP: begin
            if (!empty) begin
               dec_state = S_DUMP_RD;
            end
         end
         default: begin
            dec_state = S_RESP;
         end
      endcase
   end

   // shift extent: insert moves entries idx..occ-1 up from the top down,
   // delete moves entries idx+1..occ-1 down from the bottom up
   always_comb begin
      if (req_cmd == CMD_DUMP) begin
         dec_left = cnt_ff;
         dec_ptr  = '0;
      end else if (dec_ins) begin
         dec_left = CW'(occ_x - dec_idx);
         dec_ptr  = AW'(occ_x - KW'(1));
      end else begin
         dec_left = CW'(occ_x - KW'(1) - dec_idx);
         dec_ptr  = AW'(dec_idx + KW'(1));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = dec_state;
            end
         end
         S_MOVE: begin
            if (left_ff == '0 && !pend_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            state_in = S_DUMP_WAIT;
         end
         S_DUMP_WAIT: begin
            if (out_free) begin
               state_in = (left_ff == CW'(1)) ? S_IDLE : S_DUMP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath, memory requests and result loads
   always_comb begin
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      idx_in       = idx_ff;
      ins_in       = ins_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      mem_req      = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               val_in    = req_value;
               status_in = dec_status;
               ins_in    = dec_ins;
               idx_in    = AW'(dec_idx);
               left_in   = dec_left;
               ptr_in    = dec_ptr;
            end
         end
         S_MOVE: begin
            // read one entry per cycle, write it one slot over in the next cycle
            if (left_ff != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = MEM_AW'(ptr_ff);
               pend_in         = 1'b1;
               pend_addr_in    = ins_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
               ptr_in          = ins_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
               left_in         = left_ff - CW'(1);
            end
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = MEM_AW'(pend_addr_ff);
               mem_req.wr_data = rd_data;
            end else if (left_ff == '0) begin
               // shift done: drop the new value into its slot or shrink the list
               if (ins_ff) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = MEM_AW'(idx_ff);
                  mem_req.wr_data = val_ff;
                  cnt_in          = cnt_ff + CW'(1);
               end else begin
                  cnt_in = cnt_ff - CW'(1);
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(cnt_ff);
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
            end
         end
         S_DUMP_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = MEM_AW'(ptr_ff);
         end
         S_DUMP_WAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_count_in  = COUNT_W'(cnt_ff);
               rsp_value_in  = rd_data;
               rsp_last_in   = (left_ff == CW'(1));
               ptr_in        = ptr_ff + AW'(1);
               left_in       = left_ff - CW'(1);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_ff       <= left_in;
      ptr_ff        <= ptr_in;
      pend_addr_ff  <= pend_addr_in;
      idx_ff        <= idx_in;
      ins_ff        <= ins_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_value_ff, rsp_count_ff, rsp_status_ff});

endmodule

[hdl/ple_store.sv]
// ple_store: entry memory of the positional list engine
// one write port, one registered read port; read data holds between reads
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_store #(
   parameter int DEPTH = 32
) (
   input  logic                      clock,
   input  ple_pkg::mem_req_type      mem_req,
   output logic [ple_pkg::VAL_W-1:0] rd_data_ff
);
   import ple_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [VAL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr[AW-1:0]];
      end
   end

endmodule

[hdl/ple_checker.sv]
// ple_checker: port-level checks for the positional list engine
// bound to positional_list_engine at the end of this file
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_checker #(
   parameter int DEPTH = 32
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ple_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import ple_pkg::*;

   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;
   logic [VAL_W-1:0]    value;

   assign status = rsp_tdata[RSP_STAT_LSB +: STATUS_W];
   assign count  = rsp_tdata[RSP_CNT_LSB +: COUNT_W];
   assign value  = rsp_tdata[RSP_VAL_LSB +: VAL_W];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // one command at a time: no accept on the cycle after an accept
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while previous one busy");

   // only dump produces non-final results, and those carry ok status
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> status == STAT_OK)
      else $error("non-final result with error status");

   // an error result is a single final item with no data
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != STAT_OK |-> rsp_tlast && value == '0
      && (status != STAT_FULL || count == COUNT_W'(DEPTH)))
      else $error("malformed error result");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (.*);
